FILE: sv/mfa_pkg.sv
package mfa_pkg;

	localparam int FRAC_BITS = 16;

	localparam int IN_W    = 32;
	localparam int OMEGA_W = 31;
	localparam int OUT_W   = 48;
	localparam int ACC_W   = 64;

	localparam int DRE_W = IN_W + 1;
	localparam int DIM_W = IN_W + 2;
	localparam int MAG_W = IN_W;
	localparam int NUM_W = MAG_W + 2 * FRAC_BITS;
	localparam int DEN_W = 2 * IN_W + 2;
	localparam int Q_W   = 2 * FRAC_BITS + 1;
	localparam int R_W   = Q_W + 1;
	localparam int P_W   = 2 * IN_W + 1;
	localparam int PQ_W  = P_W - FRAC_BITS;
	localparam int HI_W  = IN_W;
	localparam int LO_W  = PQ_W - HI_W;
	localparam int MUL_A = (R_W > DIM_W) ? R_W : DIM_W;
	localparam int MUL_W = (MUL_A > LO_W + 1) ? MUL_A : LO_W + 1;
	localparam int T_W   = R_W + PQ_W + 1;
	localparam int TS_W  = T_W - FRAC_BITS;
	localparam int SUM_W = TS_W + 1;
	localparam int CNT_W = $clog2(NUM_W + 1);

	localparam int S_TDATA_W = ((6 * IN_W + OMEGA_W + 7) / 8) * 8;
	localparam int M_TDATA_W = 2 * OUT_W;
	localparam int M_TUSER_W = 2;

	localparam int STEP_W     = 4;
	localparam int PROD_STEPS = 6;
	localparam int TERM_STEPS = 8;

	typedef enum logic [2:0] {
		A_DRE, A_DIM, A_VNR, A_VNI, A_PQR_LO, A_PQR_HI, A_PQI_LO, A_PQI_HI
	} a_sel_t;

	typedef enum logic [2:0] {
		B_DRE, B_DIM, B_VMR, B_VMI, B_RRE, B_RIM
	} b_sel_t;

	typedef enum logic [1:0] {
		OP_LOAD, OP_ADD, OP_SUB
	} op_t;

	typedef enum logic [2:0] {
		T_DEN, T_PR, T_PI, T_TR, T_TI
	} tgt_t;

	typedef struct packed {
		logic   load;
		logic   mul_en;
		a_sel_t a_sel;
		b_sel_t b_sel;
		op_t    op;
		logic   shift_hi;
		tgt_t   tgt;
		logic   div_start;
		logic   set_singular;
		logic   acc_update;
		logic   emit;
	} dp_cmd_t;

	typedef struct packed {
		logic den_zero;
		logic div_done;
		logic last;
		logic out_busy;
	} dp_stat_t;

endpackage

FILE: sv/mfa_div.sv
module mfa_div import mfa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [Q_W-1:0]   quo
);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] nq_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W+1:0] diff;
	logic             ge;

	assign rem_sh = {rem_q, nq_q[NUM_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
	assign ge     = ~diff[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	// one quotient bit per cycle, shifted in where the numerator leaves
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			nq_q  <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			nq_q  <= {nq_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = nq_q[Q_W-1:0];

endmodule

FILE: sv/mfa_dp.sv
module mfa_dp import mfa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tlast,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [M_TUSER_W-1:0] m_tuser
);

	logic signed [IN_W-1:0]  in_lre, in_lim;
	logic        [OMEGA_W-1:0] in_w;

	logic signed [DRE_W-1:0] dre_q;
	logic signed [DIM_W-1:0] dim_q;
	logic signed [IN_W-1:0]  vnr_q, vni_q, vmr_q, vmi_q;
	logic                    last_q;
	logic        [DEN_W-1:0] den_q;
	logic signed [P_W-1:0]   pr_q, pi_q;
	logic signed [T_W-1:0]   tr_q, ti_q;
	logic signed [R_W-1:0]   rre_q, rim_q;
	logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
	logic                    sat_q, sing_q;

	logic signed [2*MUL_W-1:0] prod_s1;
	logic                      mv_s1, sh_s1;
	op_t                       op_s1;
	tgt_t                      tgt_s1;

	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [PQ_W-1:0]  pqr, pqi;
	logic signed [T_W-1:0]   ext, cur, res;

	logic [DRE_W-1:0] mag_re_w;
	logic [DIM_W-1:0] mag_im_w;
	logic [NUM_W-1:0] num_re, num_im;
	logic [Q_W-1:0]   q_re, q_im;
	logic             done_re, done_im;

	logic signed [SUM_W-1:0] sum_re, sum_im;
	logic                    fit_re, fit_im;
	logic                    ofit_re, ofit_im;
	logic signed [ACC_W-1:0] accn_re, accn_im;
	logic signed [OUT_W-1:0] h_re, h_im;

	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [M_TUSER_W-1:0] m_tuser_q;

	assign in_lre = s_tdata[IN_W-1:0];
	assign in_lim = s_tdata[2*IN_W-1:IN_W];
	assign in_w   = s_tdata[6*IN_W+OMEGA_W-1:6*IN_W];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dre_q  <= DRE_W'(0) - DRE_W'(in_lre);
			dim_q  <= DIM_W'($signed({1'b0, in_w})) - DIM_W'(in_lim);
			vnr_q  <= s_tdata[3*IN_W-1:2*IN_W];
			vni_q  <= s_tdata[4*IN_W-1:3*IN_W];
			vmr_q  <= s_tdata[5*IN_W-1:4*IN_W];
			vmi_q  <= s_tdata[6*IN_W-1:5*IN_W];
			last_q <= s_tlast;
		end
	end

	assign pqr = $signed(pr_q[P_W-1:FRAC_BITS]);
	assign pqi = $signed(pi_q[P_W-1:FRAC_BITS]);

	always_comb begin
		case (cmd.a_sel)
			A_DRE:    mul_a = MUL_W'(dre_q);
			A_DIM:    mul_a = MUL_W'(dim_q);
			A_VNR:    mul_a = MUL_W'(vnr_q);
			A_VNI:    mul_a = MUL_W'(vni_q);
			A_PQR_LO: mul_a = MUL_W'($signed({1'b0, pqr[LO_W-1:0]}));
			A_PQR_HI: mul_a = MUL_W'($signed(pqr[PQ_W-1:LO_W]));
			A_PQI_LO: mul_a = MUL_W'($signed({1'b0, pqi[LO_W-1:0]}));
			A_PQI_HI: mul_a = MUL_W'($signed(pqi[PQ_W-1:LO_W]));
			default:  mul_a = '0;
		endcase
		case (cmd.b_sel)
			B_DRE:   mul_b = MUL_W'(dre_q);
			B_DIM:   mul_b = MUL_W'(dim_q);
			B_VMR:   mul_b = MUL_W'(vmr_q);
			B_VMI:   mul_b = MUL_W'(vmi_q);
			B_RRE:   mul_b = MUL_W'(rre_q);
			B_RIM:   mul_b = MUL_W'(rim_q);
			default: mul_b = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mv_s1 <= 1'b0;
		else
			mv_s1 <= cmd.mul_en;
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		op_s1   <= cmd.op;
		sh_s1   <= cmd.shift_hi;
		tgt_s1  <= cmd.tgt;
	end

	// fold the registered product into its target, upper partials moved up
	always_comb begin
		ext = T_W'(prod_s1);
		if (sh_s1)
			ext = ext <<< LO_W;
		case (tgt_s1)
			T_DEN:   cur = T_W'($signed({1'b0, den_q}));
			T_PR:    cur = T_W'(pr_q);
			T_PI:    cur = T_W'(pi_q);
			T_TR:    cur = tr_q;
			T_TI:    cur = ti_q;
			default: cur = '0;
		endcase
		case (op_s1)
			OP_LOAD: res = ext;
			OP_ADD:  res = cur + ext;
			OP_SUB:  res = cur - ext;
			default: res = cur;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mv_s1) begin
			case (tgt_s1)
				T_DEN:   den_q <= res[DEN_W-1:0];
				T_PR:    pr_q  <= res[P_W-1:0];
				T_PI:    pi_q  <= res[P_W-1:0];
				T_TR:    tr_q  <= res;
				T_TI:    ti_q  <= res;
				default: ;
			endcase
		end
	end

	assign mag_re_w = dre_q[DRE_W-1] ? DRE_W'(0) - dre_q : dre_q;
	assign mag_im_w = dim_q[DIM_W-1] ? DIM_W'(0) - dim_q : dim_q;
	assign num_re   = {mag_re_w[MAG_W-1:0], {(2*FRAC_BITS){1'b0}}};
	assign num_im   = {mag_im_w[MAG_W-1:0], {(2*FRAC_BITS){1'b0}}};

	mfa_div u_div_re (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_re),
		.den    (den_q),
		.done   (done_re),
		.quo    (q_re)
	);

	mfa_div u_div_im (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_im),
		.den    (den_q),
		.done   (done_im),
		.quo    (q_im)
	);

	// reciprocal of i*w - lambda: real part follows Dre, imaginary part opposes Dim
	always_ff @(posedge clk) begin
		if (done_re) begin
			rre_q <= dre_q[DRE_W-1] ? R_W'(0) - R_W'({1'b0, q_re}) : R_W'({1'b0, q_re});
			rim_q <= dim_q[DIM_W-1] ? R_W'({1'b0, q_im}) : R_W'(0) - R_W'({1'b0, q_im});
		end
	end

	assign sum_re = SUM_W'($signed(tr_q[T_W-1:FRAC_BITS])) + SUM_W'(acc_re_q);
	assign sum_im = SUM_W'($signed(ti_q[T_W-1:FRAC_BITS])) + SUM_W'(acc_im_q);
	assign fit_re = (&sum_re[SUM_W-1:ACC_W-1]) | ~(|sum_re[SUM_W-1:ACC_W-1]);
	assign fit_im = (&sum_im[SUM_W-1:ACC_W-1]) | ~(|sum_im[SUM_W-1:ACC_W-1]);

	always_comb begin
		if (fit_re)
			accn_re = sum_re[ACC_W-1:0];
		else
			accn_re = sum_re[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		if (fit_im)
			accn_im = sum_im[ACC_W-1:0];
		else
			accn_im = sum_im[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
	end

	assign ofit_re = (&acc_re_q[ACC_W-1:OUT_W-1]) | ~(|acc_re_q[ACC_W-1:OUT_W-1]);
	assign ofit_im = (&acc_im_q[ACC_W-1:OUT_W-1]) | ~(|acc_im_q[ACC_W-1:OUT_W-1]);

	always_comb begin
		if (ofit_re)
			h_re = acc_re_q[OUT_W-1:0];
		else
			h_re = acc_re_q[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
		if (ofit_im)
			h_im = acc_im_q[OUT_W-1:0];
		else
			h_im = acc_im_q[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
			sat_q    <= 1'b0;
			sing_q   <= 1'b0;
		end else if (cmd.emit) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
			sat_q    <= 1'b0;
			sing_q   <= 1'b0;
		end else begin
			if (cmd.acc_update) begin
				acc_re_q <= accn_re;
				acc_im_q <= accn_im;
				if (!fit_re || !fit_im)
					sat_q <= 1'b1;
			end
			if (cmd.set_singular)
				sing_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (cmd.emit)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_tdata_q <= {h_im, h_re};
			m_tuser_q <= {sing_q, sat_q | ~ofit_re | ~ofit_im};
		end
	end

	assign stat.den_zero = (den_q == '0);
	assign stat.div_done = done_re & done_im;
	assign stat.last     = last_q;
	assign stat.out_busy = m_tvalid_q & ~m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

FILE: sv/mfa_ctrl.sv
module mfa_ctrl import mfa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_PROD = 7'b0000010,
		S_CHK  = 7'b0000100,
		S_DIV  = 7'b0001000,
		S_TERM = 7'b0010000,
		S_ACC  = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
				if (s_tvalid) begin
					state_d = S_PROD;
					step_d  = '0;
				end
			end
			S_PROD: begin
				// denominator, then the complex product of the mode vector entries
				cmd.mul_en = (step_q < STEP_W'(PROD_STEPS));
				case (step_q)
					STEP_W'(0): begin
						cmd.a_sel = A_DRE; cmd.b_sel = B_DRE; cmd.op = OP_LOAD; cmd.tgt = T_DEN;
					end
					STEP_W'(1): begin
						cmd.a_sel = A_DIM; cmd.b_sel = B_DIM; cmd.op = OP_ADD; cmd.tgt = T_DEN;
					end
					STEP_W'(2): begin
						cmd.a_sel = A_VNR; cmd.b_sel = B_VMR; cmd.op = OP_LOAD; cmd.tgt = T_PR;
					end
					STEP_W'(3): begin
						cmd.a_sel = A_VNI; cmd.b_sel = B_VMI; cmd.op = OP_SUB; cmd.tgt = T_PR;
					end
					STEP_W'(4): begin
						cmd.a_sel = A_VNR; cmd.b_sel = B_VMI; cmd.op = OP_LOAD; cmd.tgt = T_PI;
					end
					STEP_W'(5): begin
						cmd.a_sel = A_VNI; cmd.b_sel = B_VMR; cmd.op = OP_ADD; cmd.tgt = T_PI;
					end
					default: ;
				endcase
				if (step_q == STEP_W'(PROD_STEPS)) begin
					state_d = S_CHK;
					step_d  = '0;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			S_CHK: begin
				if (stat.den_zero) begin
					cmd.set_singular = 1'b1;
					state_d          = S_FIN;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (stat.div_done)
					state_d = S_TERM;
			end
			S_TERM: begin
				// each wide factor goes through the multiplier as a low and a high part
				cmd.mul_en = (step_q < STEP_W'(TERM_STEPS));
				case (step_q)
					STEP_W'(0): begin
						cmd.a_sel = A_PQR_LO; cmd.b_sel = B_RRE; cmd.op = OP_LOAD; cmd.tgt = T_TR;
					end
					STEP_W'(1): begin
						cmd.a_sel = A_PQR_HI; cmd.b_sel = B_RRE; cmd.op = OP_ADD; cmd.tgt = T_TR;
						cmd.shift_hi = 1'b1;
					end
					STEP_W'(2): begin
						cmd.a_sel = A_PQI_LO; cmd.b_sel = B_RIM; cmd.op = OP_SUB; cmd.tgt = T_TR;
					end
					STEP_W'(3): begin
						cmd.a_sel = A_PQI_HI; cmd.b_sel = B_RIM; cmd.op = OP_SUB; cmd.tgt = T_TR;
						cmd.shift_hi = 1'b1;
					end
					STEP_W'(4): begin
						cmd.a_sel = A_PQR_LO; cmd.b_sel = B_RIM; cmd.op = OP_LOAD; cmd.tgt = T_TI;
					end
					STEP_W'(5): begin
						cmd.a_sel = A_PQR_HI; cmd.b_sel = B_RIM; cmd.op = OP_ADD; cmd.tgt = T_TI;
						cmd.shift_hi = 1'b1;
					end
					STEP_W'(6): begin
						cmd.a_sel = A_PQI_LO; cmd.b_sel = B_RRE; cmd.op = OP_ADD; cmd.tgt = T_TI;
					end
					STEP_W'(7): begin
						cmd.a_sel = A_PQI_HI; cmd.b_sel = B_RRE; cmd.op = OP_ADD; cmd.tgt = T_TI;
						cmd.shift_hi = 1'b1;
					end
					default: ;
				endcase
				if (step_q == STEP_W'(TERM_STEPS)) begin
					state_d = S_ACC;
					step_d  = '0;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			S_ACC: begin
				cmd.acc_update = 1'b1;
				state_d        = S_FIN;
			end
			S_FIN: begin
				// for the item marked last, hold while an earlier result still waits for its transfer
				if (!stat.last) begin
					state_d = S_IDLE;
				end else if (!stat.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
				step_d  = '0;
			end
		endcase
	end

endmodule

FILE: sv/modal_frf_accumulator_core.sv
// A result is registered on the output after the item marked last has passed the product,
// check, divide, term, accumulate and finish states; a zero denominator skips to finish.
// One mode at a time; the time per mode is set by the two restoring dividers that
// produce one quotient bit per cycle over 64 steps; 14 shared multiplier passes add the rest.
// Reset (arst_n low, asynchronous) clears the accumulator, the sticky flags and the
// output valid; the block takes an item in the first cycle after reset.
module modal_frf_accumulator_core import mfa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// lambda_re, lambda_im, vn_re, vn_im, vm_re, vm_im, omega, zero pad
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// h_re, h_im
	output logic [M_TDATA_W-1:0] m_tdata,
	// saturated, singular
	output logic [M_TUSER_W-1:0] m_tuser
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	mfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mfa_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.cmd      (cmd),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: sv/mfa_checker.sv
module mfa_checker import mfa_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// a mode takes many cycles, so no second transfer right behind the first
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken in back-to-back cycles");

	// a result appears only at the end of a mode's work
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result raised while input side was idle");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped before transfer");

	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

endmodule

bind modal_frf_accumulator_core mfa_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
